// File: sv/ilse_pkg.sv
package ilse_pkg;

  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;

  // Port widths fixed by the interface
  localparam int OP_W    = 4;
  localparam int POS_W   = 5;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;

  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  // Working width for logical positions and the fill count
  localparam int LW      = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 4'd0,
    OP_POP_FRONT  = 4'd1,
    OP_PEEK_FRONT = 4'd2,
    OP_PUSH_BACK  = 4'd3,
    OP_POP_BACK   = 4'd4,
    OP_PEEK_BACK  = 4'd5,
    OP_INSERT     = 4'd6,
    OP_REMOVE     = 4'd7,
    OP_REVERSE    = 4'd8,
    OP_SIZE       = 4'd9
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [DATA_W-1:0] word;
  } cell_ctl_t;

endpackage

// File: sv/indexed_list_stack_engine.sv
// Latency: a request accepted at one edge shows its result, with out_valid high,
// in the cycle right after; out_valid is high for that single cycle only.
// Throughput: one request per cycle; busy stays low, as every shift of the cell
// chain and the fill update finish in the cycle of acceptance.
// Reset (rst_n low, synchronous): the list empties, the order returns to normal
// and out_valid drops; stored words are left as they are.
module indexed_list_stack_engine
  import ilse_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    in_op,
  input  logic [POS_W-1:0]   in_position,
  input  logic [WORD_W-1:0]  in_word_in,
  output logic               out_valid,
  output logic [WORD_W-1:0]  out_word_out,
  output logic [COUNT_W-1:0] out_count,
  output logic [STAT_W-1:0]  out_status
);

  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic               rev_r, rev_nxt;
  logic               valid_r;
  logic [WORD_W-1:0]  word_r, word_nxt;
  logic [COUNT_W-1:0] count_r;
  status_t            status_r, status_nxt;

  logic               accept;
  logic               is_ins, is_rem, is_peek, is_rev;
  logic               ins_ok, rem_ok, rd_ok;
  logic [LW-1:0]      fill_l, pos_l, lpos, cpos;
  logic               full, empty;
  logic [IDX_W-1:0]   q_idx;
  cell_ctl_t          ctl;

  logic [DATA_W-1:0]  cell_data [DEPTH];
  logic [DEPTH-1:0]   sel;
  logic [DEPTH:0]     after;

  assign accept = start & ~busy;
  assign busy   = 1'b0;

  assign fill_l = LW'(fill_r);
  assign pos_l  = LW'(in_position);
  assign full   = (fill_r == CNT_W'(DEPTH));
  assign empty  = (fill_r == '0);

  // Decode the request and pick its logical position
  always_comb begin
    is_ins  = 1'b0;
    is_rem  = 1'b0;
    is_peek = 1'b0;
    is_rev  = 1'b0;
    lpos    = '0;
    unique case (op_t'(in_op))
      OP_PUSH_FRONT: begin is_ins  = 1'b1; lpos = '0;              end
      OP_PUSH_BACK:  begin is_ins  = 1'b1; lpos = fill_l;          end
      OP_INSERT:     begin is_ins  = 1'b1; lpos = pos_l;           end
      OP_POP_FRONT:  begin is_rem  = 1'b1; lpos = '0;              end
      OP_POP_BACK:   begin is_rem  = 1'b1; lpos = fill_l - LW'(1); end
      OP_REMOVE:     begin is_rem  = 1'b1; lpos = pos_l;           end
      OP_PEEK_FRONT: begin is_peek = 1'b1; lpos = '0;              end
      OP_PEEK_BACK:  begin is_peek = 1'b1; lpos = fill_l - LW'(1); end
      OP_REVERSE:    begin is_rev  = 1'b1;                         end
      default:       begin end
    endcase
  end

  // Map the logical position onto a storage cell
  always_comb begin
    if (!rev_r) begin
      cpos = lpos;
    end else if (is_ins) begin
      cpos = fill_l - lpos;
    end else begin
      cpos = fill_l - LW'(1) - lpos;
    end
  end

  assign q_idx = cpos[IDX_W-1:0];

  assign ins_ok = accept & is_ins & ~full & (lpos <= fill_l);
  assign rem_ok = accept & is_rem & ~empty & (lpos < fill_l);
  assign rd_ok  = rem_ok | (accept & is_peek & ~empty);

  always_comb begin
    status_nxt = ST_OK;
    priority if (is_ins && full) begin
      status_nxt = ST_FULL;
    end else if (is_ins && !ins_ok) begin
      status_nxt = ST_RANGE;
    end else if ((is_rem || is_peek) && empty) begin
      status_nxt = ST_EMPTY;
    end else if (is_rem && !rem_ok) begin
      status_nxt = ST_RANGE;
    end else begin
      status_nxt = ST_OK;
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (ins_ok) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (rem_ok) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  assign rev_nxt  = rev_r ^ (accept & is_rev);
  assign word_nxt = rd_ok ? WORD_W'(cell_data[q_idx]) : '0;

  assign ctl.ins  = ins_ok;
  assign ctl.rem  = rem_ok;
  assign ctl.word = DATA_W'(in_word_in);

  assign after[0] = 1'b0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_W-1:0] prev_w, next_w;

    assign sel[k] = (q_idx == IDX_W'(k));

    if (k == 0) begin : g_first
      assign prev_w = cell_data[k];
    end else begin : g_mid_prev
      assign prev_w = cell_data[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign next_w = cell_data[k];
    end else begin : g_mid_next
      assign next_w = cell_data[k+1];
    end

    ilse_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .sel_i   (sel[k]),
      .after_i (after[k]),
      .after_o (after[k+1]),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .data_o  (cell_data[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      rev_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      fill_r  <= fill_nxt;
      rev_r   <= rev_nxt;
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_r   <= word_nxt;
      count_r  <= COUNT_W'(fill_nxt);
      status_r <= status_nxt;
    end
  end

  assign out_valid    = valid_r;
  assign out_word_out = word_r;
  assign out_count    = count_r;
  assign out_status   = status_r;

endmodule

// File: sv/ilse_cell.sv
module ilse_cell
  import ilse_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic              sel_i,
  input  logic              after_i,
  output logic              after_o,
  input  logic [DATA_W-1:0] prev_i,
  input  logic [DATA_W-1:0] next_i,
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  // Tell the right neighbor that the target cell lies at or left of it
  assign after_o = after_i | sel_i;

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (sel_i) begin
        data_nxt = ctl.word;
      end else if (after_i) begin
        data_nxt = prev_i;
      end
    end else if (ctl.rem) begin
      if (sel_i || after_i) begin
        data_nxt = next_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

// File: sv/ilse_checker.sv
module ilse_checker
  import ilse_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic [WORD_W-1:0]  out_word_out,
  input logic [COUNT_W-1:0] out_count,
  input logic [STAT_W-1:0]  out_status
);

  logic acc;
  assign acc = rst_n & start & ~busy;

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid)
    else $error("accepted request gave no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> !out_valid)
    else $error("result without a request");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_word_out == '0))
    else $error("failed request returned data");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_count == COUNT_W'(DEPTH)))
    else $error("full status with list not full");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_count == '0))
    else $error("empty status with list not empty");

endmodule

bind indexed_list_stack_engine ilse_checker u_ilse_checker (.*);

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ilse_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd10;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;
  localparam int RANDOM_REQS = 950;
  localparam int QUIET_LIMIT = 400;
  localparam int PRINT_CAP   = 150;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} stim_mode_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
  } list_req_t;

  typedef struct {
    logic [WORD_W-1:0]  word;
    logic [COUNT_W-1:0] count;
    status_t            status;
  } list_reply_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [OP_W-1:0]    in_op = '0;
  logic [POS_W-1:0]   in_position = '0;
  logic [WORD_W-1:0]  in_word_in = '0;
  logic               out_valid;
  logic [WORD_W-1:0]  out_word_out;
  logic [COUNT_W-1:0] out_count;
  logic [STAT_W-1:0]  out_status;

  indexed_list_stack_engine i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_position  (in_position),
    .in_word_in   (in_word_in),
    .out_valid    (out_valid),
    .out_word_out (out_word_out),
    .out_count    (out_count),
    .out_status   (out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  list_req_t   stim_q[$];
  list_reply_t list_replies_q[$];
  list_req_t   next_req;
  list_reply_t want;

  // Predicted list contents, mirrored from accepted requests
  logic [DATA_W-1:0] list_cells [DEPTH];
  int                list_fill = 0;
  bit                list_flipped = 1'b0;

  int plan_fill = 0;
  int error_count = 0;
  int reqs_accepted = 0;
  int replies_checked = 0;
  int full_reached = 0;
  int flipped_data_ops = 0;
  int stat_tally [4] = '{0, 0, 0, 0};
  int burst_left = 1;
  int gap_left = 0;
  int quiet_cycles = 0;

  function automatic list_reply_t predict_list_op(logic [OP_W-1:0] op_code,
                                                  logic [POS_W-1:0] pos,
                                                  logic [WORD_W-1:0] word);
    list_reply_t r;
    int p;
    int q;
    int k;
    r.word = '0;
    r.status = ST_OK;
    case (op_code)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
        if (list_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          p = (op_code == OP_PUSH_FRONT) ? 0 :
              (op_code == OP_PUSH_BACK) ? list_fill : int'(pos);
          if (p > list_fill) begin
            r.status = ST_RANGE;
          end else begin
            q = list_flipped ? list_fill - p : p;
            for (k = list_fill; k > q; k--) list_cells[k] = list_cells[k-1];
            list_cells[q] = word;
            list_fill++;
            if (list_fill == DEPTH) full_reached++;
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_REMOVE: begin
        if (list_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          p = (op_code == OP_POP_FRONT) ? 0 :
              (op_code == OP_POP_BACK) ? list_fill - 1 : int'(pos);
          if (p >= list_fill) begin
            r.status = ST_RANGE;
          end else begin
            q = list_flipped ? list_fill - 1 - p : p;
            r.word = list_cells[q];
            for (k = q; k + 1 < list_fill; k++) list_cells[k] = list_cells[k+1];
            list_fill--;
          end
        end
      end
      OP_PEEK_FRONT, OP_PEEK_BACK: begin
        if (list_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          p = (op_code == OP_PEEK_FRONT) ? 0 : list_fill - 1;
          r.word = list_cells[list_flipped ? list_fill - 1 - p : p];
        end
      end
      OP_REVERSE: list_flipped = !list_flipped;
      default: ;
    endcase
    if (list_flipped && op_code <= OP_REMOVE) flipped_data_ops++;
    stat_tally[r.status]++;
    r.count = COUNT_W'(list_fill);
    return r;
  endfunction

  // Queue a request and track the fill it leaves, to steer positions
  task automatic queue_req(logic [OP_W-1:0] op_code, logic [POS_W-1:0] pos,
                           logic [WORD_W-1:0] word);
    list_req_t r;
    int p;
    r.op = op_code;
    r.pos = pos;
    r.word = word;
    stim_q.push_back(r);
    case (op_code)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
        p = (op_code == OP_INSERT) ? int'(pos) : 0;
        if (plan_fill < DEPTH && p <= plan_fill) plan_fill++;
      end
      OP_POP_FRONT, OP_POP_BACK, OP_REMOVE: begin
        p = (op_code == OP_REMOVE) ? int'(pos) : 0;
        if (plan_fill > 0 && p < plan_fill) plan_fill--;
      end
      default: ;
    endcase
  endtask

  task automatic queue_random_req(stim_mode_t mode);
    int grow_w;
    int shrink_w;
    int roll;
    logic [OP_W-1:0]  op_code;
    logic [POS_W-1:0] pos;
    grow_w = (mode == MODE_GROW) ? 55 : (mode == MODE_SHRINK) ? 15 : 37;
    shrink_w = (mode == MODE_SHRINK) ? 55 : (mode == MODE_GROW) ? 15 : 37;
    roll = $urandom_range(0, 99);
    pos = POS_W'($urandom_range(0, 31));
    if (roll < grow_w) begin
      case ($urandom_range(0, 2))
        0: op_code = OP_PUSH_FRONT;
        1: op_code = OP_PUSH_BACK;
        default: begin
          op_code = OP_INSERT;
          if ($urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(0, plan_fill));
        end
      endcase
    end else if (roll < grow_w + shrink_w) begin
      case ($urandom_range(0, 2))
        0: op_code = OP_POP_FRONT;
        1: op_code = OP_POP_BACK;
        default: begin
          op_code = OP_REMOVE;
          if (plan_fill > 0 && $urandom_range(0, 99) < 85)
            pos = POS_W'($urandom_range(0, plan_fill - 1));
        end
      endcase
    end else if (roll < grow_w + shrink_w + 8) begin
      op_code = OP_REVERSE;
    end else if (roll < grow_w + shrink_w + 12) begin
      op_code = OP_SIZE;
    end else if (roll < grow_w + shrink_w + 15) begin
      op_code = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    end else begin
      op_code = $urandom_range(0, 1) ? OP_PEEK_FRONT : OP_PEEK_BACK;
    end
    queue_req(op_code, pos, $urandom);
  endtask

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Driver: bursts of requests with random gaps; hold start until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        list_replies_q.push_back(predict_list_op(in_op, in_position, in_word_in));
        reqs_accepted++;
      end
      if (!start || !busy) begin
        if (gap_left > 0 || stim_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          start <= 1'b0;
          in_op <= OP_W'($urandom);
          in_position <= POS_W'($urandom);
          in_word_in <= $urandom;
        end else begin
          next_req = stim_q.pop_front();
          start <= 1'b1;
          in_op <= next_req.op;
          in_position <= next_req.pos;
          in_word_in <= next_req.word;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(20, 80);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 8);
            gap_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 12 : 3);
          end
        end
      end
    end
  end

  // Monitor: every strobed reply must match the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) begin
      replies_checked++;
      if (list_replies_q.size() == 0) begin
        report_mismatch($sformatf("reply with no request outstanding: word %h count %0d status %0d",
                                  out_word_out, out_count, out_status));
      end else begin
        want = list_replies_q.pop_front();
        if (out_word_out !== want.word || out_count !== want.count ||
            out_status !== want.status)
          report_mismatch($sformatf("reply %0d: word %h/%h count %0d/%0d status %0d/%0d (got/exp)",
                                    replies_checked, out_word_out, want.word, out_count,
                                    want.count, out_status, want.status));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Stalled for %0d cycles with %0d requests and %0d replies pending",
                 quiet_cycles, stim_q.size(), list_replies_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin : main
    int made;
    int seg_len;
    stim_mode_t mode;

    // Empty list: every read fails, reverse still flips
    queue_req(OP_POP_FRONT, 5'd0, 32'h0);
    queue_req(OP_PEEK_FRONT, 5'd31, 32'hFFFF_FFFF);
    queue_req(OP_POP_BACK, 5'd0, 32'h0);
    queue_req(OP_PEEK_BACK, 5'd0, 32'h0);
    queue_req(OP_REMOVE, 5'd0, 32'h0);
    queue_req(OP_REVERSE, 5'd0, 32'h0);
    queue_req(OP_REVERSE, 5'd0, 32'h0);
    queue_req(OP_SIZE, 5'd0, 32'h0);
    // Fill a little, hit both index bounds
    queue_req(OP_PUSH_FRONT, 5'd0, 32'hFFFF_FFFF);
    queue_req(OP_PUSH_BACK, 5'd0, 32'h0000_0000);
    queue_req(OP_INSERT, 5'd31, 32'hDEAD_BEEF);
    queue_req(OP_INSERT, 5'd2, 32'hA5A5_A5A5);
    queue_req(OP_INSERT, 5'd1, 32'h5A5A_5A5A);
    queue_req(OP_REMOVE, 5'd4, 32'h0);
    queue_req(OP_REMOVE, 5'd16, 32'h0);
    queue_req(OP_PEEK_FRONT, 5'd0, 32'h0);
    queue_req(OP_PEEK_BACK, 5'd0, 32'h0);
    // Reversed order remaps every logical position
    queue_req(OP_REVERSE, 5'd0, 32'h0);
    queue_req(OP_PEEK_FRONT, 5'd0, 32'h0);
    queue_req(OP_REMOVE, 5'd1, 32'h0);
    queue_req(OP_INSERT, 5'd0, 32'h1234_5678);
    queue_req(OP_INSERT, 5'd4, 32'h8765_4321);
    queue_req(OP_POP_BACK, 5'd0, 32'h0);
    queue_req(OP_SIZE, 5'd0, 32'h0);
    queue_req(OP_SPARE_HI, 5'd31, 32'hFFFF_FFFF);
    queue_req(OP_SPARE_LO, 5'd0, 32'h0);
    queue_req(OP_POP_FRONT, 5'd0, 32'h0);

    // Random segments lean toward growing, shrinking or neither
    made = 0;
    while (made < RANDOM_REQS) begin
      mode = stim_mode_t'($urandom_range(0, 2));
      seg_len = $urandom_range(8, 48);
      repeat (seg_len) queue_random_req(mode);
      made += seg_len;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || start || list_replies_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);

    $display("Checked %0d replies for %0d requests; list full %0d times, %0d data ops reversed",
             replies_checked, reqs_accepted, full_reached, flipped_data_ops);
    $display("Status mix: ok %0d, empty %0d, full %0d, out of range %0d",
             stat_tally[ST_OK], stat_tally[ST_EMPTY], stat_tally[ST_FULL], stat_tally[ST_RANGE]);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/ilse_pkg.sv
sv/ilse_cell.sv
sv/indexed_list_stack_engine.sv
sv/ilse_checker.sv
verif/testbench.sv
